### hdl/fblik_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fblik_pkg
// Shared types and constants of the five-bar leg inverse kinematics core.
// ----------------------------------------------------------------------------
package fblik_pkg;

  localparam int unsigned LEN_W  = 15;
  localparam int unsigned ANG_W  = 14;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned EXT_W  = 34;   // sign-extended coordinate
  localparam int unsigned MAG_W  = 32;   // coordinate magnitude
  localparam int unsigned ACC_W  = 98;   // wide product accumulators
  localparam int unsigned VEC_W  = 56;   // cordic vector
  localparam int unsigned TH_W   = 34;   // angle, q30 radians

  localparam logic [ANG_W-1:0] ANG_MAX = ANG_W'(11520);
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint SCALE_MUL   = 2 * 4068 * 64;
  localparam longint SCALE_BIAS  = 71 * (64'sd1 <<< 29);
  // divide by 71 as multiply by ceil(2^29 / 71), exact for 23-bit numerators
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [22:0] RECIP_71    = 23'd7561563;

  typedef enum logic [1:0] {
    REG_UPPER   = 2'd0,
    REG_LOWER   = 2'd1,
    REG_SPACING = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [EXT_W-1:0] x;
    logic [MAG_W-1:0]        y_mag;
    logic                    y_neg;
    logic [DUTY_W-1:0]       duty;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_MUL, ST_ACC, ST_CHECK, ST_CMP, ST_SQRT, ST_VEC,
    ST_NORM, ST_ROT, ST_CORD, ST_SCALE, ST_SCALE2, ST_DIV, ST_CLAMP,
    ST_SIDE, ST_OUT
  } solve_state_e;

  typedef enum logic [3:0] {
    OP_WW, OP_YY, OP_AA, OP_BB, OP_AW, OP_AY,
    OP_EHH, OP_EHL, OP_ELL, OP_FHH, OP_FHL, OP_FLL,
    OP_GHH, OP_GHL, OP_GLL
  } mul_op_e;

  typedef enum logic [2:0] {
    DST_POS, DST_NB, DST_EP, DST_FP, DST_P, DST_D
  } acc_dest_e;

  function automatic logic signed [TH_W-1:0] atan_step(input logic [4:0] idx);
    logic signed [TH_W-1:0] val;
    case (idx)
      5'd0:    val = TH_W'(843314857);
      5'd1:    val = TH_W'(497837829);
      5'd2:    val = TH_W'(263043837);
      5'd3:    val = TH_W'(133525159);
      5'd4:    val = TH_W'(67021687);
      5'd5:    val = TH_W'(33543516);
      5'd6:    val = TH_W'(16775851);
      5'd7:    val = TH_W'(8388437);
      5'd8:    val = TH_W'(4194283);
      5'd9:    val = TH_W'(2097149);
      5'd10:   val = TH_W'(1048576);
      default: val = TH_W'(1) << (5'd30 - idx);
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

### hdl/fblik_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fblik_front
// Accepts targets and prepares them: sign extension and y magnitude.
// ----------------------------------------------------------------------------
module fblik_front #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                          push_i,
  input  logic signed [CoordWidth-1:0]  target_x_i,
  input  logic signed [CoordWidth-1:0]  target_y_i,
  input  logic [fblik_pkg::DUTY_W-1:0]  duty_in_i,
  input  logic                          q_full_i,
  output logic                          full_o,
  output logic                          wr_o,
  output fblik_pkg::item_t              item_o
);
  import fblik_pkg::*;

  logic signed [EXT_W-1:0] y_ext;
  logic [EXT_W-1:0]        y_abs;

  assign y_ext = EXT_W'(target_y_i);
  assign y_abs = y_ext[EXT_W-1] ? EXT_W'(-y_ext) : EXT_W'(y_ext);

  assign full_o       = q_full_i;
  assign wr_o         = push_i && !q_full_i;
  assign item_o.x     = EXT_W'(target_x_i);
  assign item_o.y_mag = y_abs[MAG_W-1:0];
  assign item_o.y_neg = y_ext[EXT_W-1];
  assign item_o.duty  = duty_in_i;

endmodule
`default_nettype wire

### hdl/fblik_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fblik_queue
// Two-entry queue of prepared items between front and solver.
// ----------------------------------------------------------------------------
module fblik_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  fblik_pkg::item_t item_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output fblik_pkg::item_t item_o
);
  import fblik_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= !wr_ptr_q;
      if (rd_i) rd_ptr_q <= !rd_ptr_q;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 2'd1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule
`default_nettype wire

### hdl/fblik_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fblik_solver
// Sequenced solver: shared multiplier, bit-serial root, cordic, scaling,
// and the result register.
// ----------------------------------------------------------------------------
module fblik_solver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  fblik_pkg::item_t             item_i,
  output logic                         item_pop_o,
  input  logic [fblik_pkg::LEN_W-1:0]  upper_len_i,
  input  logic [fblik_pkg::LEN_W-1:0]  lower_len_i,
  input  logic [fblik_pkg::LEN_W-1:0]  spacing_i,
  output logic                         res_valid_o,
  input  logic                         res_pop_i,
  output logic [fblik_pkg::ANG_W-1:0]  left_angle_o,
  output logic [fblik_pkg::ANG_W-1:0]  right_angle_o,
  output logic [fblik_pkg::DUTY_W-1:0] duty_out_o,
  output logic                         left_held_o,
  output logic                         right_held_o
);
  import fblik_pkg::*;

  localparam logic signed [VEC_W-1:0] LIM41 = VEC_W'(64'sd1 <<< 41);
  localparam logic signed [VEC_W-1:0] LIM49 = VEC_W'(64'sd1 <<< 49);

  solve_state_e state_q, state_d;
  logic         side_q;
  mul_op_e      op_q;
  logic [5:0]   cnt_q;
  logic         out_valid_q;
  logic [ANG_W-1:0] last_left_q, last_right_q;

  item_t        item_q;
  logic [63:0]  prod_q;
  logic [65:0]  pos_q;
  logic [29:0]  nb_q;
  logic [46:0]  ep_q, fp_q;
  logic [ACC_W-1:0] p_q, d_q;
  logic [47:0]  gmag_q;
  logic         gneg_q;
  logic [51:0]  rem_q;
  logic [47:0]  root_q;
  logic [95:0]  rad_q;
  logic signed [VEC_W-1:0] vx_q, vy_q;
  logic signed [TH_W-1:0]  th_q;
  logic [22:0]  dnum_q;
  logic [ANG_W-1:0] res_ang_q;
  logic         res_held_q, left_held_q, right_held_q;
  logic [ANG_W-1:0]  out_left_q, out_right_q;
  logic [DUTY_W-1:0] out_duty_q;
  logic         out_lh_q, out_rh_q;

  // per-side operands
  logic signed [34:0] w_s;
  logic [34:0]  w_abs;
  logic         w_neg;
  logic [31:0]  w_mag;
  logic [31:0]  opa, opb;
  logic [5:0]   sh;
  acc_dest_e    dst;
  logic [ACC_W-1:0] sp;
  logic [65:0]  gdiff;
  logic         gneg_c, g_far, p_lt_d;
  logic [51:0]  rem_pre, sq_trial;
  logic signed [VEC_W-1:0] gsig, e2, f2, sroot, vec_x, vec_y, xs, ys;
  logic         small8, small1, vzero;
  logic signed [TH_W-1:0] step;
  logic [64:0]  scaled;
  logic [45:0]  quot_full;
  logic         out_load;

  assign w_s   = 35'(item_q.x) - $signed({20'd0, side_q ? spacing_i : 15'd0});
  assign w_neg = w_s[34];
  assign w_abs = w_neg ? 35'(-w_s) : 35'(w_s);
  assign w_mag = w_abs[31:0];

  always_comb begin
    opa = 32'd0;
    opb = 32'd0;
    sh  = 6'd0;
    dst = DST_POS;
    if (state_q == ST_SCALE) begin
      opa = th_q[31:0];
      opb = 32'(SCALE_MUL);
    end else begin
      unique case (op_q)
        OP_WW:  begin opa = w_mag;              opb = w_mag; end
        OP_YY:  begin opa = item_q.y_mag;       opb = item_q.y_mag; end
        OP_AA:  begin opa = 32'(upper_len_i);   opb = 32'(upper_len_i); end
        OP_BB:  begin opa = 32'(lower_len_i);   opb = 32'(lower_len_i); dst = DST_NB; end
        OP_AW:  begin opa = 32'(upper_len_i);   opb = w_mag; dst = DST_EP; end
        OP_AY:  begin opa = 32'(upper_len_i);   opb = item_q.y_mag; dst = DST_FP; end
        OP_EHH: begin opa = 32'(ep_q[39:20]);   opb = 32'(ep_q[39:20]); sh = 6'd42; dst = DST_P; end
        OP_EHL: begin opa = 32'(ep_q[39:20]);   opb = 32'(ep_q[19:0]);  sh = 6'd23; dst = DST_P; end
        OP_ELL: begin opa = 32'(ep_q[19:0]);    opb = 32'(ep_q[19:0]);  sh = 6'd2;  dst = DST_P; end
        OP_FHH: begin opa = 32'(fp_q[39:20]);   opb = 32'(fp_q[39:20]); sh = 6'd42; dst = DST_P; end
        OP_FHL: begin opa = 32'(fp_q[39:20]);   opb = 32'(fp_q[19:0]);  sh = 6'd23; dst = DST_P; end
        OP_FLL: begin opa = 32'(fp_q[19:0]);    opb = 32'(fp_q[19:0]);  sh = 6'd2;  dst = DST_P; end
        OP_GHH: begin opa = 32'(gmag_q[47:24]); opb = 32'(gmag_q[47:24]); sh = 6'd48; dst = DST_D; end
        OP_GHL: begin opa = 32'(gmag_q[47:24]); opb = 32'(gmag_q[23:0]);  sh = 6'd25; dst = DST_D; end
        OP_GLL: begin opa = 32'(gmag_q[23:0]);  opb = 32'(gmag_q[23:0]);  dst = DST_D; end
        default: begin opa = 32'd0; opb = 32'd0; end
      endcase
    end
  end

  assign sp = ACC_W'(prod_q) << sh;

  // sign and size of g = w^2 + y^2 + a^2 - b^2
  assign gneg_c = pos_q < {36'd0, nb_q};
  assign gdiff  = gneg_c ? ({36'd0, nb_q} - pos_q) : (pos_q - {36'd0, nb_q});
  assign g_far  = |gdiff[65:48];
  assign p_lt_d = p_q < d_q;

  assign rem_pre  = {rem_q[49:0], rad_q[95:94]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  // x = g - e, y = -f +/- s, with e = -2*a*w and f = -2*a*y
  assign gsig  = gneg_q ? -$signed({8'd0, gmag_q}) : $signed({8'd0, gmag_q});
  assign e2    = $signed({8'd0, ep_q, 1'b0});
  assign f2    = $signed({8'd0, fp_q, 1'b0});
  assign sroot = $signed({8'd0, root_q});
  assign vec_x = gsig + (w_neg ? -e2 : e2);
  assign vec_y = (item_q.y_neg ? -f2 : f2) + (side_q ? -sroot : sroot);

  assign vzero  = (vx_q == '0) && (vy_q == '0);
  assign small8 = (vx_q > -LIM41) && (vx_q < LIM41) && (vy_q > -LIM41) && (vy_q < LIM41);
  assign small1 = (vx_q > -LIM49) && (vx_q < LIM49) && (vy_q > -LIM49) && (vy_q < LIM49);

  assign xs   = vx_q >>> cnt_q[4:0];
  assign ys   = vy_q >>> cnt_q[4:0];
  assign step = atan_step(cnt_q[4:0]);

  assign scaled    = {1'b0, prod_q} + 65'(SCALE_BIAS);
  assign quot_full = dnum_q * RECIP_71;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (item_valid_i) state_d = ST_INIT;
      ST_INIT:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_ACC;
      ST_ACC: begin
        if (op_q == OP_AY) state_d = ST_CHECK;
        else if (op_q == OP_GLL) state_d = ST_CMP;
        else state_d = ST_MUL;
      end
      ST_CHECK:  state_d = g_far ? ST_SIDE : ST_MUL;
      ST_CMP:    state_d = p_lt_d ? ST_SIDE : ST_SQRT;
      ST_SQRT:   if (cnt_q == 6'd47) state_d = ST_VEC;
      ST_VEC:    state_d = ST_NORM;
      ST_NORM: begin
        if (vzero) state_d = ST_SCALE;
        else if (!small1) state_d = ST_ROT;
      end
      ST_ROT:    state_d = ST_CORD;
      ST_CORD:   if (cnt_q == 6'd30) state_d = ST_SCALE;
      ST_SCALE:  state_d = (th_q <= 0) ? ST_SIDE : ST_SCALE2;
      ST_SCALE2: state_d = ST_DIV;
      ST_DIV:    state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_SIDE;
      ST_SIDE:   state_d = side_q ? ST_OUT : ST_INIT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    out_load   = (state_q == ST_OUT) && (!out_valid_q || res_pop_i);
  end

  assign res_valid_o   = out_valid_q;
  assign left_angle_o  = out_left_q;
  assign right_angle_o = out_right_q;
  assign duty_out_o    = out_duty_q;
  assign left_held_o   = out_lh_q;
  assign right_held_o  = out_rh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      side_q       <= 1'b0;
      op_q         <= OP_WW;
      cnt_q        <= 6'd0;
      out_valid_q  <= 1'b0;
      last_left_q  <= '0;
      last_right_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_pop_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE:   side_q <= 1'b0;
        ST_INIT:   op_q <= OP_WW;
        ST_ACC:    op_q <= mul_op_e'(4'(op_q + 4'd1));
        ST_CMP:    cnt_q <= 6'd0;
        ST_SQRT:   cnt_q <= cnt_q + 6'd1;
        ST_ROT:    cnt_q <= 6'd0;
        ST_CORD:   cnt_q <= cnt_q + 6'd1;
        ST_SIDE: begin
          side_q <= 1'b1;
          if (!res_held_q) begin
            if (side_q) last_right_q <= res_ang_q;
            else last_left_q <= res_ang_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= last_left_q;
      out_right_q <= last_right_q;
      out_duty_q  <= item_q.duty;
      out_lh_q    <= left_held_q;
      out_rh_q    <= right_held_q;
    end
    unique case (state_q)
      ST_IDLE: if (item_valid_i) item_q <= item_i;
      ST_INIT: begin
        pos_q <= '0;
        p_q   <= '0;
        d_q   <= '0;
      end
      ST_MUL, ST_SCALE: begin
        prod_q    <= opa * opb;
        res_ang_q <= '0;
      end
      ST_ACC: begin
        unique case (dst)
          DST_POS: pos_q <= pos_q + sp[65:0];
          DST_NB:  nb_q  <= prod_q[29:0];
          DST_EP:  ep_q  <= prod_q[46:0];
          DST_FP:  fp_q  <= prod_q[46:0];
          DST_P:   p_q   <= p_q + sp;
          DST_D:   d_q   <= d_q + sp;
          default: ;
        endcase
      end
      ST_CHECK: begin
        res_held_q <= g_far;
        gneg_q     <= gneg_c;
        gmag_q     <= gdiff[47:0];
      end
      ST_CMP: begin
        res_held_q <= p_lt_d;
        rad_q      <= 96'(p_q - d_q);
        rem_q      <= '0;
        root_q     <= '0;
      end
      ST_SQRT: begin
        rad_q <= {rad_q[93:0], 2'b00};
        if (rem_pre >= sq_trial) begin
          rem_q  <= rem_pre - sq_trial;
          root_q <= {root_q[46:0], 1'b1};
        end else begin
          rem_q  <= rem_pre;
          root_q <= {root_q[46:0], 1'b0};
        end
      end
      ST_VEC: begin
        vx_q <= vec_x;
        vy_q <= vec_y;
      end
      ST_NORM: begin
        if (vzero) th_q <= '0;
        else if (small8) begin
          vx_q <= vx_q <<< 8;
          vy_q <= vy_q <<< 8;
        end else if (small1) begin
          vx_q <= vx_q <<< 1;
          vy_q <= vy_q <<< 1;
        end
      end
      ST_ROT: begin
        // fold the left half plane onto the right one
        if (vx_q < 0) begin
          if (vy_q >= 0) begin
            vx_q <= vy_q;
            vy_q <= -vx_q;
            th_q <= TH_W'(HALF_PI_Q30);
          end else begin
            vx_q <= -vy_q;
            vy_q <= vx_q;
            th_q <= -TH_W'(HALF_PI_Q30);
          end
        end else begin
          th_q <= '0;
        end
      end
      ST_CORD: begin
        if (vy_q < 0) begin
          vx_q <= vx_q - ys;
          vy_q <= vy_q + xs;
          th_q <= th_q - step;
        end else begin
          vx_q <= vx_q + ys;
          vy_q <= vy_q - xs;
          th_q <= th_q + step;
        end
      end
      ST_SCALE2: dnum_q <= scaled[52:30];
      ST_DIV:    dnum_q <= 23'(quot_full >> RECIP_SHIFT);
      ST_CLAMP: res_ang_q <= (dnum_q > 23'(ANG_MAX)) ? ANG_MAX : dnum_q[ANG_W-1:0];
      ST_SIDE: begin
        if (side_q) right_held_q <= res_held_q;
        else left_held_q <= res_held_q;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/five_bar_leg_inverse_kinematics_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics_core
// Joint angles of a symmetric five-bar leg from a foot target.
// ----------------------------------------------------------------------------
// Targets go in through a queue-style port (push/full) and land in a
// two-entry queue, so two can be waiting while one is solved. The solver
// works one item at a time and does both cranks in turn on one shared
// 32x32 multiplier, a one-bit-per-cycle square root and a 31-step
// cordic, then scales to 1/64 degree with a reciprocal multiply for the
// divide by 71. An unreachable crank skips the root and the cordic. Results
// leave through empty/pop from an output register. The user must set link
// lengths through the config port only while the block is idle; the block
// itself does not enforce this.
module five_bar_leg_inverse_kinematics_core #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] target_x_i,
  input  logic signed [COORD_WIDTH-1:0] target_y_i,
  input  logic [fblik_pkg::DUTY_W-1:0]  duty_in_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [fblik_pkg::ANG_W-1:0]   left_angle_o,
  output logic [fblik_pkg::ANG_W-1:0]   right_angle_o,
  output logic [fblik_pkg::DUTY_W-1:0]  duty_out_o,
  output logic                          left_held_o,
  output logic                          right_held_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [fblik_pkg::LEN_W-1:0]   cfg_data_i
);
  import fblik_pkg::*;

  logic [LEN_W-1:0] upper_q, lower_q, spacing_q;
  logic  q_full, q_wr, q_valid, q_rd, res_valid;
  item_t fr_item, q_item;

  assign cfg_ready_o = 1'b1;
  assign empty       = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= LEN_W'(800);
      lower_q   <= LEN_W'(1600);
      spacing_q <= LEN_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_UPPER:   upper_q   <= cfg_data_i;
        REG_LOWER:   lower_q   <= cfg_data_i;
        REG_SPACING: spacing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fblik_front #(.CoordWidth(COORD_WIDTH)) u_front (
    .push_i     (push),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .duty_in_i  (duty_in_i),
    .q_full_i   (q_full),
    .full_o     (full),
    .wr_o       (q_wr),
    .item_o     (fr_item)
  );

  fblik_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .item_i  (fr_item),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  fblik_solver u_solver (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_pop_o    (q_rd),
    .upper_len_i   (upper_q),
    .lower_len_i   (lower_q),
    .spacing_i     (spacing_q),
    .res_valid_o   (res_valid),
    .res_pop_i     (pop),
    .left_angle_o  (left_angle_o),
    .right_angle_o (right_angle_o),
    .duty_out_o    (duty_out_o),
    .left_held_o   (left_held_o),
    .right_held_o  (right_held_o)
  );

endmodule
`default_nettype wire

### hdl/fblik_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fblik_checker
// Port-level checks of the result side of the leg kinematics core.
// ----------------------------------------------------------------------------
module fblik_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [fblik_pkg::ANG_W-1:0] left_angle_o,
  input logic [fblik_pkg::ANG_W-1:0] right_angle_o,
  input logic                        left_held_o,
  input logic                        right_held_o
);
  import fblik_pkg::*;

  logic [ANG_W-1:0] prev_left_q, prev_right_q;

  // angles of the last item taken; both start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else if (pop && !empty) begin
      prev_left_q  <= left_angle_o;
      prev_right_q <= right_angle_o;
    end
  end

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (left_angle_o <= ANG_MAX) && (right_angle_o <= ANG_MAX))
    else $error("angle out of range");

  a_left_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && left_held_o) |-> (left_angle_o == prev_left_q))
    else $error("held left angle changed");

  a_right_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && right_held_o) |-> (right_angle_o == prev_right_q))
    else $error("held right angle changed");

  a_result_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(left_angle_o) && $stable(right_angle_o)))
    else $error("result dropped before pop");

endmodule

bind five_bar_leg_inverse_kinematics_core fblik_checker u_fblik_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .left_angle_o  (left_angle_o),
  .right_angle_o (right_angle_o),
  .left_held_o   (left_held_o),
  .right_held_o  (right_held_o)
);
`default_nettype wire

### sim/five_bar_leg_inverse_kinematics_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics_core_tb
// Self-checking bench for the five-bar leg joint angle solver.
// ----------------------------------------------------------------------------
// A directed table (range extremes, unreachable targets, zero-length links,
// reachable poses) is followed by random targets aimed mostly inside the
// reach of the current link setting. Every accepted target is solved again
// by a bit-exact model in this bench and each popped result is checked
// field by field. Link lengths change between phases while the core is
// idle, and the push/pop sides idle at several rates.
module five_bar_leg_inverse_kinematics_core_tb;
  import fblik_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_PER_PHASE = 140;
  localparam int NUM_PHASES = 5;
  localparam longint NORM_LIMIT = 64'sd1 <<< 49;
  localparam longint G_LIMIT = 64'sd1 <<< 48;
  localparam longint DEG_DIV = 71 * (64'sd1 <<< 30);

  typedef struct {
    logic [ANG_W-1:0]  left;
    logic [ANG_W-1:0]  right;
    logic [DUTY_W-1:0] duty;
    logic              left_held;
    logic              right_held;
  } leg_pose_t;

  typedef struct {
    leg_pose_t pose;
    bit        typed;
    leg_pose_t typed_pose;
  } pose_entry_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         duty;
    bit                 typed;
    leg_pose_t          typed_pose;
  } target_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic signed [15:0]   target_x_i;
  logic signed [15:0]   target_y_i;
  logic [DUTY_W-1:0]    duty_in_i;
  logic                 empty;
  logic                 pop;
  logic [ANG_W-1:0]     left_angle_o;
  logic [ANG_W-1:0]     right_angle_o;
  logic [DUTY_W-1:0]    duty_out_o;
  logic                 left_held_o;
  logic                 right_held_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i;
  logic [LEN_W-1:0]     cfg_data_i;

  five_bar_leg_inverse_kinematics_core #(.COORD_WIDTH(16)) dut (.*);

  // joint geometry as the core should hold it
  longint upper_len, lower_len, spacing;
  logic [ANG_W-1:0] held_left, held_right;

  pose_entry_t pending_poses[$];
  bit          cur_typed;
  leg_pose_t   cur_typed_pose;
  int          errors, targets_in, poses_out, held_seen, watchdog;
  int          gap_pct, stall_pct;

  const longint atan_tbl[11] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

  initial begin
    clk_i = 1'b0;
    forever begin
      #2 clk_i = 1'b1;
      #2 clk_i = 1'b0;
    end
  end

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // atan2(yv, xv) in q30 radians, cordic vectoring
  function automatic longint cordic_atan2(longint xv, longint yv);
    longint th, t, stp, xs, ys;
    th = 0;
    if (xv == 0 && yv == 0) return 0;
    while (abs64(xv) < NORM_LIMIT && abs64(yv) < NORM_LIMIT) begin
      xv = xv * 2;
      yv = yv * 2;
    end
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; th = HALF_PI_Q30;
      end else begin
        xv = -yv; yv = t; th = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i <= 30; i++) begin
      stp = (i < 11) ? atan_tbl[i] : (64'sd1 <<< (30 - i));
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv < 0) begin
        xv = xv - ys; yv = yv + xs; th = th - stp;
      end else begin
        xv = xv + ys; yv = yv - xs; th = th + stp;
      end
    end
    return th;
  endfunction

  // crank angle in 1/64 degree, -1 when the target is out of reach
  function automatic int crank_angle(longint w, longint yv, bit plus_root);
    longint gmag, g, e, f, s, yy, xx, th, deg, pos, nb;
    logic [127:0] p, d, diff, t;
    bit gneg;
    pos = w * w + yv * yv + upper_len * upper_len;
    nb = lower_len * lower_len;
    gneg = pos < nb;
    gmag = gneg ? nb - pos : pos - nb;
    if (gmag >= G_LIMIT) return -1;
    e = -2 * upper_len * w;
    f = -2 * upper_len * yv;
    p = 128'(abs64(e)) * 128'(abs64(e)) + 128'(abs64(f)) * 128'(abs64(f));
    d = 128'(gmag) * 128'(gmag);
    if (p < d) return -1;
    diff = p - d;
    s = 0;
    for (int b = 47; b >= 0; b--) begin
      t = 128'(s | (64'sd1 <<< b));
      if (!(diff < t * t)) s = s | (64'sd1 <<< b);
    end
    g = gneg ? -gmag : gmag;
    yy = plus_root ? -f + s : -f - s;
    xx = g - e;
    th = cordic_atan2(xx, yy);
    if (th <= 0) return 0;
    deg = (th * SCALE_MUL + SCALE_BIAS) / DEG_DIV;
    if (deg > longint'(ANG_MAX)) deg = ANG_MAX;
    return int'(deg);
  endfunction

  function automatic leg_pose_t solve_leg(logic signed [15:0] xt, logic signed [15:0] yt,
                                          logic [7:0] duty);
    leg_pose_t res;
    int la, ra;
    la = crank_angle(longint'(xt), longint'(yt), 1'b1);
    ra = crank_angle(longint'(xt) - spacing, longint'(yt), 1'b0);
    res.left_held = la < 0;
    res.right_held = ra < 0;
    if (la >= 0) held_left = ANG_W'(la);
    if (ra >= 0) held_right = ANG_W'(ra);
    res.left = held_left;
    res.right = held_right;
    res.duty = duty;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, poses_out);
    errors++;
  endtask

  task automatic check_pose(leg_pose_t want, string tag);
    if (left_angle_o !== want.left) report({tag, " left_angle"}, left_angle_o, want.left);
    if (right_angle_o !== want.right) report({tag, " right_angle"}, right_angle_o, want.right);
    if (duty_out_o !== want.duty) report({tag, " duty_out"}, duty_out_o, want.duty);
    if (left_held_o !== want.left_held)
      report({tag, " left_held"}, left_held_o, want.left_held);
    if (right_held_o !== want.right_held)
      report({tag, " right_held"}, right_held_o, want.right_held);
  endtask

  // predict on accepted items, check accepted results, watch for a hang
  always @(posedge clk_i) begin
    pose_entry_t ent;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        ent.pose = solve_leg(target_x_i, target_y_i, duty_in_i);
        ent.typed = cur_typed;
        ent.typed_pose = cur_typed_pose;
        pending_poses.push_back(ent);
        targets_in++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (pending_poses.size() == 0) begin
          $display("mismatch: result with no item waiting");
          errors++;
        end else begin
          ent = pending_poses.pop_front();
          check_pose(ent.pose, "model");
          if (ent.typed) check_pose(ent.typed_pose, "table");
          if (left_held_o || right_held_o) held_seen++;
        end
        poses_out++;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
      watchdog = moved ? 0 : watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_target(logic signed [15:0] xt, logic signed [15:0] yt,
                             logic [7:0] duty, bit typed, leg_pose_t tp);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    target_x_i <= xt;
    target_y_i <= yt;
    duty_in_i <= duty;
    cur_typed <= typed;
    cur_typed_pose <= tp;
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain;
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [LEN_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_UPPER:   upper_len = val;
      REG_LOWER:   lower_len = val;
      REG_SPACING: spacing = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(int up, int lo, int sp);
    write_reg(REG_UPPER, LEN_W'(up));
    write_reg(REG_LOWER, LEN_W'(lo));
    write_reg(REG_SPACING, LEN_W'(sp));
  endtask

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // mostly targets inside the leg's reach, some noise over the full range
  task automatic send_random_target;
    int reach, xv, yv;
    leg_pose_t none;
    none = '{default: '0};
    reach = int'(upper_len + lower_len);
    if (reach < 16) reach = 16;
    if ($urandom_range(0, 99) < 15) begin
      xv = $signed(16'($urandom()));
      yv = $signed(16'($urandom()));
    end else begin
      xv = int'(spacing / 2) + int'($urandom_range(0, 2 * reach)) - reach;
      yv = -int'($urandom_range(0, reach));
      if ($urandom_range(0, 3) == 0) yv = -yv;
    end
    send_target(sat16(xv), sat16(yv), 8'($urandom_range(0, 255)), 1'b0, none);
  endtask

  target_row_t table_rows[$];
  leg_pose_t   no_pose;

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    target_x_i = '0;
    target_y_i = '0;
    duty_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_UPPER;
    cfg_data_i = '0;
    cur_typed = 1'b0;
    upper_len = 800;
    lower_len = 1600;
    spacing = 480;
    held_left = '0;
    held_right = '0;
    errors = 0;
    targets_in = 0;
    poses_out = 0;
    held_seen = 0;
    watchdog = 0;
    gap_pct = 0;
    stall_pct = 0;
    no_pose = '{default: '0};
    cur_typed_pose = no_pose;

    // out of reach right after reset: angles stay zero, both flags up
    table_rows.push_back('{16'sd32767, 16'sd32767, 8'hff, 1'b1, '{0, 0, 8'hff, 1, 1}});
    table_rows.push_back('{-16'sd32768, -16'sd32768, 8'h00, 1'b1, '{0, 0, 8'h00, 1, 1}});
    table_rows.push_back('{16'sd0, 16'sd0, 8'haa, 1'b1, '{0, 0, 8'haa, 1, 1}});
    table_rows.push_back('{16'sd240, -16'sd1800, 8'h55, 1'b0, no_pose});
    table_rows.push_back('{16'sd240, -16'sd1200, 8'h01, 1'b0, no_pose});
    table_rows.push_back('{16'sd0, -16'sd2000, 8'h80, 1'b0, no_pose});
    table_rows.push_back('{16'sd480, -16'sd2000, 8'h7f, 1'b0, no_pose});
    table_rows.push_back('{16'sd240, 16'sd1800, 8'h33, 1'b0, no_pose});
    table_rows.push_back('{-16'sd1000, -16'sd1500, 8'hcc, 1'b0, no_pose});
    table_rows.push_back('{16'sd1500, -16'sd1000, 8'h0f, 1'b0, no_pose});
    table_rows.push_back('{16'sd240, -16'sd2390, 8'hf0, 1'b0, no_pose});
    table_rows.push_back('{16'sd240, -16'sd850, 8'h5a, 1'b0, no_pose});
    table_rows.push_back('{-16'sd2300, 16'sd100, 8'ha5, 1'b0, no_pose});
    table_rows.push_back('{16'sd2700, 16'sd0, 8'h11, 1'b0, no_pose});
    // played with all lengths zero: zero vector and degenerate geometry
    table_rows.push_back('{16'sd0, 16'sd0, 8'h22, 1'b0, no_pose});
    table_rows.push_back('{16'sd1, 16'sd1, 8'h44, 1'b0, no_pose});
    table_rows.push_back('{-16'sd1, -16'sd1, 8'h88, 1'b0, no_pose});
    table_rows.push_back('{16'sd32767, -16'sd32768, 8'hee, 1'b0, no_pose});
    table_rows.push_back('{-16'sd32768, 16'sd32767, 8'h77, 1'b0, no_pose});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) begin
      if (i == 14) begin
        drain();
        set_geometry(0, 0, 0);
        write_reg(REG_UNUSED, LEN_W'(12345));
      end
      send_target(table_rows[i].x, table_rows[i].y, table_rows[i].duty,
                  table_rows[i].typed, table_rows[i].typed_pose);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_geometry(800, 1600, 480);
        1: set_geometry(32767, 32767, 32767);
        2: set_geometry($urandom_range(100, 4000), $urandom_range(100, 4000),
                        $urandom_range(0, 2000));
        3: set_geometry($urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767));
        default: set_geometry(3000, 1200, 0);
      endcase
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 52; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 52; end
        default: begin gap_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 2 && n == RAND_PER_PHASE / 2) drain();
        send_random_target();
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    $display("covered %0d targets over %0d link settings, %0d results with a held side",
             targets_in, NUM_PHASES + 2, held_seen);
    $display("%0d results checked, %0d mismatches", poses_out, errors);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

### five_bar_leg_inverse_kinematics_core.f
hdl/fblik_pkg.sv
hdl/fblik_front.sv
hdl/fblik_queue.sv
hdl/fblik_solver.sv
hdl/five_bar_leg_inverse_kinematics_core.sv
hdl/fblik_checker.sv
sim/five_bar_leg_inverse_kinematics_core_tb.sv
